// ===== sv/tcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcr_pkg;

	// request codes
	localparam logic [1:0] REQ_DRAW  = 2'd0;
	localparam logic [1:0] REQ_TEXEL = 2'd1;
	localparam logic [1:0] REQ_COLOR = 2'd2;

	// register indexes
	localparam logic REG_CHAR_BASE  = 1'b0;
	localparam logic REG_COLOR_BASE = 1'b1;

	// cell codes and colors
	localparam logic [7:0] CODE_SOLID  = 8'd160;
	localparam logic [7:0] CODE_BLANK  = 8'd32;
	localparam logic [7:0] FLOOR_COLOR = 8'd9;
	localparam logic [7:0] BLANK_COLOR = 8'd0;
	localparam logic [7:0] SIDE_OFFSET = 8'd2;
	localparam int         FRAC_BITS   = 4;

	// table geometry: one bank bit above an 8-bit index
	localparam int MEM_AW = 9;

	typedef enum logic [1:0] {
		KIND_BLANK,
		KIND_WALL,
		KIND_FLOOR
	} cell_kind_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [5:0] column;
		logic [7:0] wall_start;
		logic [7:0] wall_end;
		logic       side_horizontal;
		logic [7:0] texture_column;
		logic [7:0] row_step;
		logic       material;
		logic [7:0] table_index;
		logic [7:0] table_data;
	} req_t;

	typedef struct packed {
		logic [15:0] char_address;
		logic [15:0] color_address;
		logic [7:0]  char_code;
		logic [7:0]  cell_color;
		logic        last_row;
	} result_t;

	// one row travelling down the lookup pipeline
	typedef struct packed {
		logic        valid;
		cell_kind_t  kind;
		logic        last;
		logic        bank;
		logic        horiz;
		logic [15:0] offset;
	} row_t;

	// table write port
	typedef struct packed {
		logic              we;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        data;
	} load_t;

endpackage

`default_nettype wire

// ===== sv/tcr_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcr_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [15:0] char_base,
	output logic      [15:0] color_base
);

	logic [15:0] char_base_q;
	logic [15:0] color_base_q;
	logic        wr_en;
	logic        idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_base_q  <= '0;
			color_base_q <= '0;
		end else if (wr_en) begin
			case (idx)
				tcr_pkg::REG_CHAR_BASE:  char_base_q  <= pwdata[15:0];
				tcr_pkg::REG_COLOR_BASE: color_base_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			tcr_pkg::REG_CHAR_BASE:  prdata = {16'd0, char_base_q};
			tcr_pkg::REG_COLOR_BASE: prdata = {16'd0, color_base_q};
			default:                 prdata = '0;
		endcase
	end

	assign char_base  = char_base_q;
	assign color_base = color_base_q;

endmodule

`default_nettype wire

// ===== sv/tcr_row_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcr_row_gen #(
	parameter int SCREEN_ROWS = 25,
	parameter int TEXEL_SHIFT = 4,
	parameter int ROW_PITCH   = 40
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       draw_go,
	input  wire tcr_pkg::req_t              req,
	output tcr_pkg::row_t                   row,
	output logic [tcr_pkg::MEM_AW-1:0]      texel_addr,
	output logic                            active
);

	localparam int RW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;

	logic          active_q;
	logic [RW-1:0] row_q;
	logic [7:0]    acc_q;
	logic [15:0]   off_q;
	logic [7:0]    start_q;
	logic [7:0]    end_q;
	logic          bank_q;
	logic          horiz_q;
	logic [7:0]    tex_col_q;
	logic [7:0]    step_q;

	logic [7:0]          row_w;
	logic                is_last;
	tcr_pkg::cell_kind_t kind;
	logic [7:0]          tex_base;
	logic [7:0]          tex_idx;

	assign row_w   = 8'(row_q);
	assign is_last = (row_q == RW'(SCREEN_ROWS - 1));

	// classify the current row
	always_comb begin
		if (row_w >= start_q && row_w < end_q) begin
			kind = tcr_pkg::KIND_WALL;
		end else if (row_w >= end_q) begin
			kind = tcr_pkg::KIND_FLOOR;
		end else begin
			kind = tcr_pkg::KIND_BLANK;
		end
	end

	// texel index from column and accumulator integer part
	assign tex_base   = tex_col_q << TEXEL_SHIFT;
	assign tex_idx    = tex_base + {4'd0, acc_q[7:tcr_pkg::FRAC_BITS]};
	assign texel_addr = {bank_q, tex_idx};

	always_comb begin
		row.valid  = active_q;
		row.kind   = kind;
		row.last   = is_last;
		row.bank   = bank_q;
		row.horiz  = horiz_q;
		row.offset = off_q;
	end

	assign active = active_q;

	// row sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			row_q    <= '0;
			acc_q    <= '0;
		end else if (draw_go) begin
			active_q <= 1'b1;
			row_q    <= '0;
			acc_q    <= '0;
		end else if (active_q) begin
			if (kind == tcr_pkg::KIND_WALL) begin
				acc_q <= acc_q + step_q;
			end
			if (is_last) begin
				active_q <= 1'b0;
				row_q    <= '0;
			end else begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	// draw parameters and running buffer offset
	always_ff @(posedge clk) begin
		if (draw_go) begin
			off_q     <= {10'd0, req.column};
			start_q   <= req.wall_start;
			end_q     <= req.wall_end;
			bank_q    <= req.material;
			horiz_q   <= req.side_horizontal;
			tex_col_q <= req.texture_column;
			step_q    <= req.row_step;
		end else if (active_q) begin
			off_q <= off_q + 16'(ROW_PITCH);
		end
	end

endmodule

`default_nettype wire

// ===== sv/tcr_texel_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcr_texel_stage (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tcr_pkg::load_t        load,
	input  wire tcr_pkg::row_t         row_in,
	input  wire logic [tcr_pkg::MEM_AW-1:0] texel_addr,
	output tcr_pkg::row_t              row_out,
	output logic [tcr_pkg::MEM_AW-1:0] color_addr
);

	logic [7:0]    texel_mem [2**tcr_pkg::MEM_AW];
	logic [7:0]    texel_s1;
	tcr_pkg::row_t row_s1;
	logic [7:0]    ci;

	// texel store, one write and one registered read
	always_ff @(posedge clk) begin
		if (load.we) begin
			texel_mem[load.addr] <= load.data;
		end
		texel_s1 <= texel_mem[texel_addr];
	end

	// row control alongside the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_s1.valid <= 1'b0;
		end else begin
			row_s1 <= row_in;
		end
	end

	// side shading shifts the color index
	assign ci         = texel_s1 + (row_s1.horiz ? tcr_pkg::SIDE_OFFSET : 8'd0);
	assign color_addr = {row_s1.bank, ci};
	assign row_out    = row_s1;

endmodule

`default_nettype wire

// ===== sv/tcr_color_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcr_color_stage (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tcr_pkg::load_t        load,
	input  wire tcr_pkg::row_t         row_in,
	input  wire logic [tcr_pkg::MEM_AW-1:0] color_addr,
	input  wire logic [15:0]           char_base,
	input  wire logic [15:0]           color_base,
	output logic                       result_valid,
	output tcr_pkg::result_t           result,
	output logic                       pipe_busy
);

	logic [7:0]       color_mem [2**tcr_pkg::MEM_AW];
	logic [7:0]       color_s2;
	tcr_pkg::row_t    row_s2;
	logic             valid_s3;
	tcr_pkg::result_t result_s3;
	tcr_pkg::result_t res_d;

	// color table, one write and one registered read
	always_ff @(posedge clk) begin
		if (load.we) begin
			color_mem[load.addr] <= load.data;
		end
		color_s2 <= color_mem[color_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_s2.valid <= 1'b0;
		end else begin
			row_s2 <= row_in;
		end
	end

	// cell code and color per row kind
	always_comb begin
		res_d.char_address  = char_base + row_s2.offset;
		res_d.color_address = color_base + row_s2.offset;
		res_d.last_row      = row_s2.last;
		case (row_s2.kind)
			tcr_pkg::KIND_WALL: begin
				res_d.char_code  = tcr_pkg::CODE_SOLID;
				res_d.cell_color = color_s2;
			end
			tcr_pkg::KIND_FLOOR: begin
				res_d.char_code  = tcr_pkg::CODE_SOLID;
				res_d.cell_color = tcr_pkg::FLOOR_COLOR;
			end
			default: begin
				res_d.char_code  = tcr_pkg::CODE_BLANK;
				res_d.cell_color = tcr_pkg::BLANK_COLOR;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= row_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_s3 <= res_d;
	end

	assign result_valid = valid_s3;
	assign result       = result_s3;
	assign pipe_busy    = row_s2.valid || valid_s3;

endmodule

`default_nettype wire

// ===== sv/textured_column_renderer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Textured column renderer.
// Request channel: req is taken at a rising edge with start high and busy low.
// A draw request emits SCREEN_ROWS results, one per row from the top, on
// result with result_valid high for one cycle each; the receiver cannot stall
// and must take every result in the cycle it appears. A texel or color load
// request writes one table entry at its accept edge and emits nothing.
// Order: a draw row leaves the row sequencer, then passes the registered texel
// store read, the registered color table read and the output register, one row per
// cycle; busy stays high until the last row has been shown, and a load does
// not raise busy.
// The row rate is set by the row sequencer, which issues one row per cycle
// into the chained texel store and color table reads.
// Config: APB port, character buffer base at 0x0, color buffer base at 0x4;
// the user writes them only while busy is low, which the block does not enforce.
// Reset: arst_n clears the sequencer, the pipeline and both base registers;
// table contents are undefined until loaded.

module textured_column_renderer_top #(
	parameter int SCREEN_ROWS = 25,
	parameter int TEXEL_SHIFT = 4,
	parameter int ROW_PITCH   = 40
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire tcr_pkg::req_t    req,
	output logic                  result_valid,
	output tcr_pkg::result_t      result,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic      [31:0]      prdata,
	output logic                  pready
);

	logic                       accept;
	logic                       draw_go;
	logic                       gen_active;
	logic                       pipe_busy;
	logic [15:0]                char_base;
	logic [15:0]                color_base;
	tcr_pkg::row_t              row_s0;
	tcr_pkg::row_t              row_s1;
	logic [tcr_pkg::MEM_AW-1:0] texel_addr;
	logic [tcr_pkg::MEM_AW-1:0] color_addr;
	tcr_pkg::load_t             texel_load;
	tcr_pkg::load_t             color_load;

	// request decode
	assign accept  = start && !busy;
	assign draw_go = accept && (req.req_type == tcr_pkg::REQ_DRAW);

	always_comb begin
		texel_load.we   = accept && (req.req_type == tcr_pkg::REQ_TEXEL);
		texel_load.addr = {req.material, req.table_index};
		texel_load.data = req.table_data;
		color_load.we   = accept && (req.req_type == tcr_pkg::REQ_COLOR);
		color_load.addr = {req.material, req.table_index};
		color_load.data = req.table_data;
	end

	assign busy = gen_active || row_s1.valid || pipe_busy;

	tcr_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.char_base  (char_base),
		.color_base (color_base)
	);

	tcr_row_gen #(
		.SCREEN_ROWS (SCREEN_ROWS),
		.TEXEL_SHIFT (TEXEL_SHIFT),
		.ROW_PITCH   (ROW_PITCH)
	) u_row_gen (
		.clk        (clk),
		.arst_n     (arst_n),
		.draw_go    (draw_go),
		.req        (req),
		.row        (row_s0),
		.texel_addr (texel_addr),
		.active     (gen_active)
	);

	tcr_texel_stage u_texel (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (texel_load),
		.row_in     (row_s0),
		.texel_addr (texel_addr),
		.row_out    (row_s1),
		.color_addr (color_addr)
	);

	tcr_color_stage u_color (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (color_load),
		.row_in       (row_s1),
		.color_addr   (color_addr),
		.char_base    (char_base),
		.color_base   (color_base),
		.result_valid (result_valid),
		.result       (result),
		.pipe_busy    (pipe_busy)
	);

endmodule

`default_nettype wire

// ===== sv/tcr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcr_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire tcr_pkg::req_t    req,
	input wire logic             result_valid,
	input wire tcr_pkg::result_t result
);

	// results only come while a draw is in flight
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result shown while not busy");

	// an accepted draw holds off further requests
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type == tcr_pkg::REQ_DRAW) |=> busy)
		else $error("busy low after draw request");

	// rows of one column come back to back
	a_rows_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last_row) |=> result_valid)
		else $error("gap inside a column");

	// the last row closes the column
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_row) |=> !result_valid)
		else $error("result right after last row");

	// only blank or solid codes
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.char_code == tcr_pkg::CODE_SOLID ||
			result.char_code == tcr_pkg::CODE_BLANK))
		else $error("unexpected character code");

endmodule

bind textured_column_renderer_top tcr_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.req          (req),
	.result_valid (result_valid),
	.result       (result)
);

`default_nettype wire
